// File: rtl/load_store_register_unit_macros.svh
// assertion macros for the load/store register unit
// expects clk and rst in the scope where a macro is used
`ifndef LOAD_STORE_REGISTER_UNIT_MACROS_SVH
`define LOAD_STORE_REGISTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LSRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lsru_pkg.sv
// shared types, codes and helper functions of the load/store register unit
// no dependencies
package lsru_pkg;

  localparam int DATA_W = 64;
  localparam int REG_W  = 4;
  localparam int CMD_W  = 3;
  localparam int OFF_W  = 16;
  localparam int SIZE_W = 2;
  localparam int MOP_W  = 2;
  localparam int NUM_IDX = 1 << REG_W;

  localparam int NUM_REGS_DEF  = 16;
  localparam int STACK_REG_DEF = 15;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVI  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STORE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESP  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd7;

  // memory request codes
  localparam logic [MOP_W-1:0] MOP_NONE  = 2'd0;
  localparam logic [MOP_W-1:0] MOP_READ  = 2'd1;
  localparam logic [MOP_W-1:0] MOP_WRITE = 2'd2;

  // access size codes
  localparam logic [SIZE_W-1:0] SZ_BYTE  = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_HALF  = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_WORD  = 2'd2;
  localparam logic [SIZE_W-1:0] SZ_DWORD = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [REG_W-1:0]  dst_reg;
    logic [REG_W-1:0]  src_reg;
    logic [REG_W-1:0]  base_reg;
    logic signed [OFF_W-1:0] offset;
    logic [DATA_W-1:0] immediate;
    logic [SIZE_W-1:0] access_size;
    logic              sign_ext;
    logic [DATA_W-1:0] read_data;
    logic              read_fault;
  } item_t;

  typedef struct packed {
    logic [MOP_W-1:0]  mem_op;
    logic [DATA_W-1:0] mem_address;
    logic [SIZE_W-1:0] mem_size;
    logic [DATA_W-1:0] mem_write_data;
    logic              wb_valid;
    logic [REG_W-1:0]  wb_reg;
    logic [DATA_W-1:0] wb_value;
    logic              rejected;
  } result_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic fire;
  } ctrl_cmd_t;

  // data bit mask of an access size
  function automatic logic [DATA_W-1:0] size_mask(logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    case (sz)
      SZ_BYTE: m = 64'h0000_0000_0000_00FF;
      SZ_HALF: m = 64'h0000_0000_0000_FFFF;
      SZ_WORD: m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // zero or sign extension of loaded data
  function automatic logic [DATA_W-1:0] extend_data(logic [DATA_W-1:0] d,
                                                    logic [SIZE_W-1:0] sz,
                                                    logic sgn);
    logic [DATA_W-1:0] v;
    v = d & size_mask(sz);
    case (sz)
      SZ_BYTE: if (sgn && d[7]) v[DATA_W-1:8] = '1;
      SZ_HALF: if (sgn && d[15]) v[DATA_W-1:16] = '1;
      SZ_WORD: if (sgn && d[31]) v[DATA_W-1:32] = '1;
      default: v = d;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/lsru_if.sv
// valid/ready channel interfaces for items and results
// depends on lsru_pkg
interface lsru_item_if;
  logic                        valid;
  logic                        ready;
  logic [lsru_pkg::CMD_W-1:0]  command;
  logic [lsru_pkg::REG_W-1:0]  dst_reg;
  logic [lsru_pkg::REG_W-1:0]  src_reg;
  logic [lsru_pkg::REG_W-1:0]  base_reg;
  logic signed [lsru_pkg::OFF_W-1:0] offset;
  logic [lsru_pkg::DATA_W-1:0] immediate;
  logic [lsru_pkg::SIZE_W-1:0] access_size;
  logic                        sign_ext;
  logic [lsru_pkg::DATA_W-1:0] read_data;
  logic                        read_fault;

  modport source (output valid, command, dst_reg, src_reg, base_reg, offset, immediate,
                  access_size, sign_ext, read_data, read_fault, input ready);
  modport sink (input valid, command, dst_reg, src_reg, base_reg, offset, immediate,
                access_size, sign_ext, read_data, read_fault, output ready);
endinterface

interface lsru_result_if;
  logic                        valid;
  logic                        ready;
  logic [lsru_pkg::MOP_W-1:0]  mem_op;
  logic [lsru_pkg::DATA_W-1:0] mem_address;
  logic [lsru_pkg::SIZE_W-1:0] mem_size;
  logic [lsru_pkg::DATA_W-1:0] mem_write_data;
  logic                        wb_valid;
  logic [lsru_pkg::REG_W-1:0]  wb_reg;
  logic [lsru_pkg::DATA_W-1:0] wb_value;
  logic                        rejected;

  modport source (output valid, mem_op, mem_address, mem_size, mem_write_data, wb_valid,
                  wb_reg, wb_value, rejected, input ready);
  modport sink (input valid, mem_op, mem_address, mem_size, mem_write_data, wb_valid,
                wb_reg, wb_value, rejected, output ready);
endinterface

// File: rtl/load_store_register_unit.sv
// an accepted item is held while its registered register file read completes, then
// executes into the result register; no new item is taken until it has executed, and
// a stalled result holds the execute step
// reset: synchronous; clears register file valid bits, pending load and handshake
// state, so every register reads as zero with no clearing pass
module load_store_register_unit #(
  parameter int NUM_REGS  = lsru_pkg::NUM_REGS_DEF,
  parameter int STACK_REG = lsru_pkg::STACK_REG_DEF
) (
  input logic          clk,
  input logic          rst,
  lsru_item_if.sink    item,
  lsru_result_if.source result
);

  lsru_pkg::ctrl_cmd_t cmd;
  lsru_pkg::item_t     item_beat;
  lsru_pkg::result_t   result_beat;

  // pack the incoming beat
  assign item_beat.command     = item.command;
  assign item_beat.dst_reg     = item.dst_reg;
  assign item_beat.src_reg     = item.src_reg;
  assign item_beat.base_reg    = item.base_reg;
  assign item_beat.offset      = item.offset;
  assign item_beat.immediate   = item.immediate;
  assign item_beat.access_size = item.access_size;
  assign item_beat.sign_ext    = item.sign_ext;
  assign item_beat.read_data   = item.read_data;
  assign item_beat.read_fault  = item.read_fault;

  lsru_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  lsru_datapath #(
    .NUM_REGS  (NUM_REGS),
    .STACK_REG (STACK_REG)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item_beat),
    .result (result_beat)
  );

  // unpack the result beat
  assign result.mem_op         = result_beat.mem_op;
  assign result.mem_address    = result_beat.mem_address;
  assign result.mem_size       = result_beat.mem_size;
  assign result.mem_write_data = result_beat.mem_write_data;
  assign result.wb_valid       = result_beat.wb_valid;
  assign result.wb_reg         = result_beat.wb_reg;
  assign result.wb_value       = result_beat.wb_value;
  assign result.rejected       = result_beat.rejected;

endmodule

// File: rtl/lsru_regfile.sv
// register file memory: two registered read ports, one write port
// valid bits make never-written entries read as zero; depends on lsru_pkg
module lsru_regfile #(
  parameter int NUM_REGS = lsru_pkg::NUM_REGS_DEF,
  parameter int IDX_W    = $clog2(NUM_REGS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_a_addr,
  input  logic [IDX_W-1:0]            rd_b_addr,
  output logic [lsru_pkg::DATA_W-1:0] rd_a_data,
  output logic [lsru_pkg::DATA_W-1:0] rd_b_data,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [lsru_pkg::DATA_W-1:0] wr_data
);

  logic [lsru_pkg::DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]         vld;
  logic [lsru_pkg::DATA_W-1:0] a_q;
  logic [lsru_pkg::DATA_W-1:0] b_q;
  logic                        a_vld;
  logic                        b_vld;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_q   <= mem[rd_a_addr];
      b_q   <= mem[rd_b_addr];
      a_vld <= vld[rd_a_addr];
      b_vld <= vld[rd_b_addr];
    end
  end

  assign rd_a_data = a_vld ? a_q : '0;
  assign rd_b_data = b_vld ? b_q : '0;

endmodule

// File: rtl/lsru_ctrl.sv
// controller: item handshake, execute sequencing and result valid
// depends on lsru_pkg and load_store_register_unit_macros.svh
`include "load_store_register_unit_macros.svh"

module lsru_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  output logic                result_valid,
  input  logic                result_ready,
  output lsru_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   accept;
  logic   fire;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  // execute once the output register is free or being emptied
  assign fire       = (state == ST_EXEC) && (!out_valid || result_ready);

  assign cmd.capture = accept;
  assign cmd.fire    = fire;
  assign result_valid = out_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  `LSRU_ASSERT_NXT(a_accept_exec, accept, state == ST_EXEC, "accepted beat did not start execute")
  `LSRU_ASSERT_IMP(a_rose_after_exec, $rose(out_valid), $past(state) == ST_EXEC, "result without execute")
  `LSRU_ASSERT_NXT(a_stall_holds, (state == ST_EXEC) && out_valid && !result_ready, (state == ST_EXEC) && out_valid, "stalled result lost")

endmodule

// File: rtl/lsru_datapath.sv
// datapath: captured item, register file, pending load state, result register
// depends on lsru_pkg and lsru_regfile
module lsru_datapath #(
  parameter int NUM_REGS  = lsru_pkg::NUM_REGS_DEF,
  parameter int STACK_REG = lsru_pkg::STACK_REG_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lsru_pkg::ctrl_cmd_t cmd,
  input  lsru_pkg::item_t     item,
  output lsru_pkg::result_t   result
);

  localparam int IDX_W = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] SP_IDX = IDX_W'(STACK_REG % NUM_REGS);

  logic [IDX_W-1:0] idx_map [lsru_pkg::NUM_IDX];

  lsru_pkg::item_t   c_item;
  lsru_pkg::result_t res_q;
  lsru_pkg::result_t res;

  logic                        load_pending;
  logic [IDX_W-1:0]            pending_dest;
  logic [lsru_pkg::SIZE_W-1:0] pending_size;
  logic                        pending_signed;
  logic                        pending_is_pop;
  logic                        pend_set;
  logic                        pend_clr;

  logic [IDX_W-1:0]            rd_a_addr;
  logic [IDX_W-1:0]            rd_b_addr;
  logic [lsru_pkg::DATA_W-1:0] ra;
  logic [lsru_pkg::DATA_W-1:0] rb;
  logic                        wr_req;
  logic [IDX_W-1:0]            wr_addr;
  logic [lsru_pkg::DATA_W-1:0] wr_data;

  logic [IDX_W-1:0]            c_dst;
  logic [IDX_W-1:0]            c_src;
  logic [lsru_pkg::DATA_W-1:0] off64;
  logic [lsru_pkg::DATA_W-1:0] step;
  logic [lsru_pkg::DATA_W-1:0] eff_addr;
  logic [lsru_pkg::DATA_W-1:0] sp_up;
  logic [lsru_pkg::DATA_W-1:0] sp_dn;
  logic [lsru_pkg::DATA_W-1:0] ld_val;

  // register index folding, worked out at elaboration
  for (genvar i = 0; i < lsru_pkg::NUM_IDX; i++) begin : g_map
    assign idx_map[i] = IDX_W'(i % NUM_REGS);
  end

  // read addresses from the incoming beat
  always_comb begin
    rd_a_addr = idx_map[item.src_reg];
    if (item.command == lsru_pkg::CMD_PUSH || item.command == lsru_pkg::CMD_POP) begin
      rd_b_addr = SP_IDX;
    end else begin
      rd_b_addr = idx_map[item.base_reg];
    end
  end

  lsru_regfile #(
    .NUM_REGS (NUM_REGS),
    .IDX_W    (IDX_W)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (cmd.capture),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (ra),
    .rd_b_data (rb),
    .wr_en     (cmd.fire && wr_req),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_item <= item;
    end
  end

  // address arithmetic
  assign c_dst    = idx_map[c_item.dst_reg];
  assign c_src    = idx_map[c_item.src_reg];
  assign off64    = {{(lsru_pkg::DATA_W - lsru_pkg::OFF_W){c_item.offset[lsru_pkg::OFF_W-1]}},
                     c_item.offset};
  assign step     = lsru_pkg::DATA_W'(1) << c_item.access_size;
  assign eff_addr = rb + off64;
  assign sp_up    = rb + step;
  assign sp_dn    = rb - step;

  // loaded value, with the pop increment when it lands in the stack register
  always_comb begin
    ld_val = lsru_pkg::extend_data(c_item.read_data, pending_size, pending_signed);
    if (pending_is_pop && pending_dest == SP_IDX) begin
      ld_val = ld_val + (lsru_pkg::DATA_W'(1) << pending_size);
    end
  end

  // execute
  always_comb begin
    res      = '0;
    wr_req   = 1'b0;
    wr_addr  = c_dst;
    wr_data  = '0;
    pend_set = 1'b0;
    pend_clr = 1'b0;
    if (c_item.command == lsru_pkg::CMD_NONE ||
        ((c_item.command == lsru_pkg::CMD_RESP) != load_pending)) begin
      res.rejected = 1'b1;
    end else begin
      case (c_item.command) inside
        lsru_pkg::CMD_RESP: begin
          pend_clr = 1'b1;
          if (!c_item.read_fault) begin
            wr_req  = 1'b1;
            wr_addr = pending_dest;
            wr_data = ld_val;
          end
        end
        lsru_pkg::CMD_MOVE, lsru_pkg::CMD_MOVI: begin
          wr_req  = 1'b1;
          wr_addr = c_dst;
          wr_data = (c_item.command == lsru_pkg::CMD_MOVI) ? c_item.immediate : ra;
        end
        lsru_pkg::CMD_LOAD: begin
          pend_set        = 1'b1;
          res.mem_op      = lsru_pkg::MOP_READ;
          res.mem_address = eff_addr;
          res.mem_size    = c_item.access_size;
        end
        lsru_pkg::CMD_POP: begin
          pend_set        = 1'b1;
          res.mem_op      = lsru_pkg::MOP_READ;
          res.mem_address = rb;
          res.mem_size    = c_item.access_size;
          wr_req          = 1'b1;
          wr_addr         = SP_IDX;
          wr_data         = sp_up;
        end
        lsru_pkg::CMD_STORE: begin
          res.mem_op         = lsru_pkg::MOP_WRITE;
          res.mem_address    = eff_addr;
          res.mem_size       = c_item.access_size;
          res.mem_write_data = ra & lsru_pkg::size_mask(c_item.access_size);
        end
        lsru_pkg::CMD_PUSH: begin
          res.mem_op      = lsru_pkg::MOP_WRITE;
          res.mem_address = sp_dn;
          res.mem_size    = c_item.access_size;
          // pushing the stack register stores its lowered value
          if (c_src == SP_IDX) begin
            res.mem_write_data = sp_dn & lsru_pkg::size_mask(c_item.access_size);
          end else begin
            res.mem_write_data = ra & lsru_pkg::size_mask(c_item.access_size);
          end
          wr_req  = 1'b1;
          wr_addr = SP_IDX;
          wr_data = sp_dn;
        end
        default: res.rejected = 1'b1;
      endcase
      if (wr_req) begin
        res.wb_valid = 1'b1;
        res.wb_reg   = lsru_pkg::REG_W'(wr_addr);
        res.wb_value = wr_data;
      end
    end
  end

  // pending load state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pending   <= 1'b0;
      pending_dest   <= '0;
      pending_size   <= '0;
      pending_signed <= 1'b0;
      pending_is_pop <= 1'b0;
    end else if (cmd.fire) begin
      if (pend_set) begin
        load_pending   <= 1'b1;
        pending_dest   <= c_dst;
        pending_size   <= c_item.access_size;
        pending_signed <= c_item.sign_ext;
        pending_is_pop <= (c_item.command == lsru_pkg::CMD_POP);
      end else if (pend_clr) begin
        load_pending <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      res_q <= res;
    end
  end

  assign result = res_q;

endmodule
